FILE: sv/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Shared widths, command and status codes, control types and bitmap helpers
// for the slot pool allocator.
// ----------------------------------------------------------------------------
package spa_pkg;

   // Pool geometry.
   localparam int POOL_SIZE = 64;
   localparam int IDX_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

   // Field widths of the request and response words.
   localparam int CMD_W    = 2;
   localparam int CNT_W    = 7;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 2;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MARK    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SWEEP   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_COMPACT = 2'd3;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

   // Datapath operation codes issued by the controller.
   localparam logic [2:0] OP_IDLE  = 3'd0;
   localparam logic [2:0] OP_SETUP = 3'd1;
   localparam logic [2:0] OP_SCAN  = 3'd2;
   localparam logic [2:0] OP_EMIT  = 3'd3;
   localparam logic [2:0] OP_FINAL = 3'd4;
   localparam logic [2:0] OP_HOLD  = 3'd5;

   typedef logic [POOL_SIZE-1:0] pool_mask_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       accept;
      logic [2:0] op;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             alloc_zero;
      logic             alloc_full;
      logic             comp_empty;
      logic             comp_nohole;
      logic             scan_done;
      logic             emit_last;
      logic             out_free;
   } dp_stat_type;

   // Index of the lowest set bit; zero when no bit is set.
   function automatic logic [IDX_W-1:0] lowest_set(input pool_mask_type v);
      logic [IDX_W-1:0] r;
      r = '0;
      for (int i = POOL_SIZE - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = IDX_W'(i);
         end
      end
      return r;
   endfunction

endpackage

FILE: sv/spa_req_if.sv
// ----------------------------------------------------------------------------
// spa_req_if
// Request channel of the slot pool allocator: one command word per handshake.
// ----------------------------------------------------------------------------
interface spa_req_if;
   logic                          valid;
   logic                          ready;
   logic [spa_pkg::CMD_W-1:0]     cmd;
   logic [spa_pkg::CNT_W-1:0]     count;
   logic [spa_pkg::SLOT_W-1:0]    slot;

   modport source (output valid, output cmd, output count, output slot, input ready);
   modport sink   (input valid, input cmd, input count, input slot, output ready);
endinterface

FILE: sv/spa_rsp_if.sv
// ----------------------------------------------------------------------------
// spa_rsp_if
// Response channel of the slot pool allocator: one result word per handshake.
// ----------------------------------------------------------------------------
interface spa_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [spa_pkg::SLOT_W-1:0]      slot_res;
   logic [spa_pkg::SLOT_W-1:0]      source_slot;
   logic                            slot_valid;
   logic [spa_pkg::STATUS_W-1:0]    status;
   logic [spa_pkg::CNT_W-1:0]       removed;
   logic [spa_pkg::CNT_W-1:0]       active_count;
   logic signed [spa_pkg::CNT_W-1:0] max_active;
   logic                            last;

   modport source (output valid, output slot_res, output source_slot, output slot_valid,
                   output status, output removed, output active_count,
                   output max_active, output last, input ready);
   modport sink   (input valid, input slot_res, input source_slot, input slot_valid,
                   input status, input removed, input active_count,
                   input max_active, input last, output ready);
endinterface

FILE: sv/spa_dp.sv
// ----------------------------------------------------------------------------
// spa_dp
// Datapath of the slot pool allocator: occupancy bitmap, removal marks,
// counters, scan masks with a lowest-bit encoder, and the response register.
// ----------------------------------------------------------------------------
module spa_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  spa_pkg::ctl_cmd_type            ctl,
   output spa_pkg::dp_stat_type            stat,
   input  logic [spa_pkg::CMD_W-1:0]       req_cmd,
   input  logic [spa_pkg::CNT_W-1:0]       req_count,
   input  logic [spa_pkg::SLOT_W-1:0]      req_slot,
   spa_rsp_if.source                       rsp_bus
);

   // Latched command word.
   logic [spa_pkg::CMD_W-1:0]        cmd_ff, cmd_in;
   logic [spa_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [spa_pkg::SLOT_W-1:0]       slot_ff, slot_in;

   // Pool state.
   spa_pkg::pool_mask_type           occ_ff, occ_in;
   spa_pkg::pool_mask_type           marks_ff, marks_in;
   logic [spa_pkg::CNT_W-1:0]        active_ff, active_in;
   logic signed [spa_pkg::CNT_W-1:0] highest_ff, highest_in;

   // Scan state: work mask (free slots, freed slots or holes), sources, counter.
   spa_pkg::pool_mask_type           work_ff, work_in;
   spa_pkg::pool_mask_type           src_ff, src_in;
   logic [spa_pkg::CNT_W-1:0]        cnt_ff, cnt_in;

   // Fields of a single closing result.
   logic [spa_pkg::SLOT_W-1:0]       fin_slot_ff, fin_slot_in;
   logic                             fin_valid_ff, fin_valid_in;
   logic [spa_pkg::STATUS_W-1:0]     fin_status_ff, fin_status_in;

   // Response register.
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [spa_pkg::SLOT_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic [spa_pkg::SLOT_W-1:0]       rsp_src_ff, rsp_src_in;
   logic                             rsp_sv_ff, rsp_sv_in;
   logic [spa_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [spa_pkg::CNT_W-1:0]        rsp_removed_ff, rsp_removed_in;
   logic [spa_pkg::CNT_W-1:0]        rsp_active_ff, rsp_active_in;
   logic signed [spa_pkg::CNT_W-1:0] rsp_max_ff, rsp_max_in;
   logic                             rsp_last_ff, rsp_last_in;

   // Helpers.
   spa_pkg::pool_mask_type           below_mask;
   spa_pkg::pool_mask_type           le_mask;
   spa_pkg::pool_mask_type           freed_mask;
   spa_pkg::pool_mask_type           work_clr;
   spa_pkg::pool_mask_type           src_clr;
   logic [spa_pkg::IDX_W-1:0]        work_low;
   logic [spa_pkg::IDX_W-1:0]        src_low;
   logic [spa_pkg::IDX_W-1:0]        free_low;
   logic [spa_pkg::CNT_W-1:0]        free_cnt;
   logic                             out_free;

   // Position masks: below the active count, and at or below the highest index.
   always_comb begin
      for (int n = 0; n < spa_pkg::POOL_SIZE; n++) begin
         below_mask[n] = (spa_pkg::CNT_W'(n) < active_ff);
         le_mask[n]    = (signed'(spa_pkg::CNT_W'(n)) <= highest_ff);
      end
   end

   assign freed_mask = occ_ff & marks_ff & le_mask;
   assign work_clr   = work_ff & (work_ff - spa_pkg::POOL_SIZE'(1));
   assign src_clr    = src_ff & (src_ff - spa_pkg::POOL_SIZE'(1));
   assign work_low   = spa_pkg::lowest_set(work_ff);
   assign src_low    = spa_pkg::lowest_set(src_ff);
   assign free_low   = spa_pkg::lowest_set(~occ_ff);
   assign free_cnt   = spa_pkg::CNT_W'(spa_pkg::POOL_SIZE) - active_ff;
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;

   // Status toward the controller.
   always_comb begin
      stat.cmd         = cmd_ff;
      stat.alloc_zero  = (count_ff == '0);
      stat.alloc_full  = (count_ff > free_cnt);
      stat.comp_empty  = (active_ff == '0);
      stat.comp_nohole = ((~occ_ff & below_mask) == '0);
      stat.scan_done   = (cmd_ff == spa_pkg::CMD_SWEEP) ? (work_ff == '0)
                                                        : (cnt_ff == spa_pkg::CNT_W'(1));
      stat.emit_last   = (cmd_ff == spa_pkg::CMD_COMPACT) ? (work_clr == '0)
                                                          : (cnt_ff == spa_pkg::CNT_W'(1));
      stat.out_free    = out_free;
   end

   // Next-state logic for the pool and the scan.
   always_comb begin
      cmd_in         = cmd_ff;
      count_in       = count_ff;
      slot_in        = slot_ff;
      occ_in         = occ_ff;
      marks_in       = marks_ff;
      active_in      = active_ff;
      highest_in     = highest_ff;
      work_in        = work_ff;
      src_in         = src_ff;
      cnt_in         = cnt_ff;
      fin_slot_in    = fin_slot_ff;
      fin_valid_in   = fin_valid_ff;
      fin_status_in  = fin_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_slot_in    = rsp_slot_ff;
      rsp_src_in     = rsp_src_ff;
      rsp_sv_in      = rsp_sv_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_active_in  = rsp_active_ff;
      rsp_max_in     = rsp_max_ff;
      rsp_last_in    = rsp_last_ff;

      if (ctl.accept) begin
         cmd_in   = req_cmd;
         count_in = req_count;
         slot_in  = req_slot;
      end

      case (ctl.op)
         // Setup step of a command: decide and prepare the scan masks.
         spa_pkg::OP_SETUP: begin
            fin_slot_in   = '0;
            fin_valid_in  = 1'b0;
            fin_status_in = spa_pkg::ST_NONE;
            case (cmd_ff)
               spa_pkg::CMD_ALLOC: begin
                  if (count_ff == '0) begin
                     fin_status_in = spa_pkg::ST_NONE;
                  end else if (count_ff > free_cnt) begin
                     fin_status_in = spa_pkg::ST_FULL;
                  end else begin
                     work_in   = ~occ_ff;
                     cnt_in    = count_ff;
                     active_in = active_ff + count_ff;
                  end
               end
               spa_pkg::CMD_MARK: begin
                  if ({1'b0, slot_ff} < spa_pkg::CNT_W'(spa_pkg::POOL_SIZE)) begin
                     marks_in[slot_ff[spa_pkg::IDX_W-1:0]] = 1'b1;
                     fin_slot_in   = slot_ff;
                     fin_valid_in  = 1'b1;
                     fin_status_in = spa_pkg::ST_OK;
                  end
               end
               spa_pkg::CMD_SWEEP: begin
                  occ_in   = occ_ff & ~freed_mask;
                  marks_in = marks_ff & ~freed_mask;
                  work_in  = freed_mask;
                  cnt_in   = '0;
               end
               spa_pkg::CMD_COMPACT: begin
                  if (active_ff != '0) begin
                     highest_in = signed'(active_ff - spa_pkg::CNT_W'(1));
                     work_in    = ~occ_ff & below_mask;
                     src_in     = occ_ff & ~below_mask;
                  end
               end
               default: begin
               end
            endcase
         end

         // Counting pass: find the last claimed slot, or count freed slots.
         spa_pkg::OP_SCAN: begin
            if (cmd_ff == spa_pkg::CMD_SWEEP) begin
               if (work_ff == '0) begin
                  active_in     = active_ff - cnt_ff;
                  fin_status_in = (cnt_ff != '0) ? spa_pkg::ST_OK : spa_pkg::ST_NONE;
               end else begin
                  work_in = work_clr;
                  cnt_in  = cnt_ff + spa_pkg::CNT_W'(1);
               end
            end else begin
               if (cnt_ff == spa_pkg::CNT_W'(1)) begin
                  if (signed'({1'b0, spa_pkg::SLOT_W'(work_low)}) > highest_ff) begin
                     highest_in = signed'({1'b0, spa_pkg::SLOT_W'(work_low)});
                  end
                  cnt_in = count_ff;
               end else begin
                  work_in = work_clr;
                  cnt_in  = cnt_ff - spa_pkg::CNT_W'(1);
               end
            end
         end

         // One allocated slot or move per cycle into the free response register.
         spa_pkg::OP_EMIT: begin
            rsp_valid_in   = 1'b1;
            rsp_sv_in      = 1'b1;
            rsp_status_in  = spa_pkg::ST_OK;
            rsp_removed_in = '0;
            rsp_active_in  = active_ff;
            rsp_max_in     = highest_ff;
            if (cmd_ff == spa_pkg::CMD_COMPACT) begin
               rsp_slot_in      = spa_pkg::SLOT_W'(work_low);
               rsp_src_in       = spa_pkg::SLOT_W'(src_low);
               rsp_last_in      = (work_clr == '0);
               occ_in[src_low]  = 1'b0;
               occ_in[work_low] = 1'b1;
               work_in          = work_clr;
               src_in           = src_clr;
            end else begin
               rsp_slot_in      = spa_pkg::SLOT_W'(free_low);
               rsp_src_in       = '0;
               rsp_last_in      = (cnt_ff == spa_pkg::CNT_W'(1));
               occ_in[free_low] = 1'b1;
               cnt_in           = cnt_ff - spa_pkg::CNT_W'(1);
            end
         end

         // Single closing result.
         spa_pkg::OP_FINAL: begin
            rsp_valid_in   = 1'b1;
            rsp_slot_in    = fin_slot_ff;
            rsp_src_in     = '0;
            rsp_sv_in      = fin_valid_ff;
            rsp_status_in  = fin_status_ff;
            rsp_removed_in = (cmd_ff == spa_pkg::CMD_SWEEP) ? cnt_ff : '0;
            rsp_active_in  = active_ff;
            rsp_max_in     = highest_ff;
            rsp_last_in    = 1'b1;
         end

         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         marks_ff     <= '0;
         active_ff    <= '0;
         highest_ff   <= -spa_pkg::CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         marks_ff     <= marks_in;
         active_ff    <= active_in;
         highest_ff   <= highest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      count_ff       <= count_in;
      slot_ff        <= slot_in;
      work_ff        <= work_in;
      src_ff         <= src_in;
      cnt_ff         <= cnt_in;
      fin_slot_ff    <= fin_slot_in;
      fin_valid_ff   <= fin_valid_in;
      fin_status_ff  <= fin_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_src_ff     <= rsp_src_in;
      rsp_sv_ff      <= rsp_sv_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_active_ff  <= rsp_active_in;
      rsp_max_ff     <= rsp_max_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Response channel.
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.slot_res     = rsp_slot_ff;
   assign rsp_bus.source_slot  = rsp_src_ff;
   assign rsp_bus.slot_valid   = rsp_sv_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.removed      = rsp_removed_ff;
   assign rsp_bus.active_count = rsp_active_ff;
   assign rsp_bus.max_active   = rsp_max_ff;
   assign rsp_bus.last         = rsp_last_ff;

   // Between commands the count matches the bitmap.
   a_count_matches_map: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == spa_pkg::OP_IDLE) |-> ($countones(occ_ff) == int'(active_ff)))
      else $error("active count differs from occupancy bitmap");

   // Between commands no occupied slot lies above the highest index.
   a_no_slot_above_highest: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == spa_pkg::OP_IDLE) |-> ((occ_ff & ~le_mask) == '0))
      else $error("occupied slot above highest active index");

   // A compaction move always goes from a higher slot to a lower hole.
   a_move_goes_down: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == spa_pkg::OP_EMIT && cmd_ff == spa_pkg::CMD_COMPACT)
         |-> (work_low < src_low && src_ff[src_low] && work_ff[work_low]))
      else $error("compaction move does not fill a lower hole");

endmodule

FILE: sv/spa_ctrl.sv
// ----------------------------------------------------------------------------
// spa_ctrl
// Controller of the slot pool allocator: sequences setup, counting scan,
// emission of results and the closing result of each command.
// ----------------------------------------------------------------------------
module spa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  spa_pkg::dp_stat_type  stat,
   output spa_pkg::ctl_cmd_type  ctl
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_EMIT  = 3'd3;
   localparam logic [2:0] S_FINAL = 3'd4;

   logic [2:0] state_ff, state_in;

   // State transitions and datapath commands.
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      ctl.accept = 1'b0;
      ctl.op     = spa_pkg::OP_HOLD;
      case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            ctl.op     = spa_pkg::OP_IDLE;
            ctl.accept = req_valid;
            if (req_valid) begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            ctl.op = spa_pkg::OP_SETUP;
            case (stat.cmd)
               spa_pkg::CMD_ALLOC: begin
                  state_in = (stat.alloc_zero || stat.alloc_full) ? S_FINAL : S_SCAN;
               end
               spa_pkg::CMD_SWEEP: begin
                  state_in = S_SCAN;
               end
               spa_pkg::CMD_COMPACT: begin
                  state_in = (stat.comp_empty || stat.comp_nohole) ? S_FINAL : S_EMIT;
               end
               default: begin
                  state_in = S_FINAL;
               end
            endcase
         end
         S_SCAN: begin
            ctl.op = spa_pkg::OP_SCAN;
            if (stat.scan_done) begin
               state_in = (stat.cmd == spa_pkg::CMD_SWEEP) ? S_FINAL : S_EMIT;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               ctl.op = spa_pkg::OP_EMIT;
               if (stat.emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_FINAL: begin
            if (stat.out_free) begin
               ctl.op   = spa_pkg::OP_FINAL;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // An accepted word always starts with its setup cycle.
   a_accept_starts_setup: assert property (@(posedge clock) disable iff (reset)
      ctl.accept |=> (state_ff == S_SETUP))
      else $error("accepted word did not enter setup");

   // The last emitted result of a run returns the controller to idle.
   a_last_emit_ends_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && stat.out_free && stat.emit_last) |=> (state_ff == S_IDLE))
      else $error("run did not end after its last result");

   // A new command word is taken only while no command is in progress.
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == S_IDLE))
      else $error("request ready outside idle");

endmodule

FILE: sv/slot_pool_alloc_free_compact.sv
// ----------------------------------------------------------------------------
// slot_pool_alloc_free_compact
// Slot pool allocator with removal marks, sweep and compaction over a
// bitmap of POOL_SIZE slots.
// ----------------------------------------------------------------------------
// Usage: one command word enters on req_bus (valid/ready); result words leave
// on rsp_bus (valid/ready), the final word of a command carrying last = 1.
// Every result word of a command shows the count and highest index as they
// stand after the whole command.
// Sequence: the block takes one command at a time. After acceptance a setup
// step follows. Allocate of k slots then counts through the free slots with
// a lowest-bit encoder and emits one slot per cycle while the output
// register is free. Sweep counts the freed slots one per cycle, then gives
// one closing word. Compact emits one move per cycle while the output
// register is free. Mark, rejected and empty commands give a single word.
// req_bus.ready is high while no command is in progress, even if a result
// word still waits in the output register.
// Stall: a result word holds in the output register until taken; emission
// pauses meanwhile and no word is lost or repeated.
// Reset: synchronous; the pool comes up empty with no marks and the highest
// index at minus one.
// ----------------------------------------------------------------------------
module slot_pool_alloc_free_compact (
   input  logic        clock,
   input  logic        reset,
   spa_req_if.sink     req_bus,
   spa_rsp_if.source   rsp_bus
);

   spa_pkg::ctl_cmd_type ctl;
   spa_pkg::dp_stat_type stat;
   logic                 req_ready;

   assign req_bus.ready = req_ready;

   spa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   spa_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .stat      (stat),
      .req_cmd   (req_bus.cmd),
      .req_count (req_bus.count),
      .req_slot  (req_bus.slot),
      .rsp_bus   (rsp_bus)
   );

endmodule
